// ===== src/assert_macros.svh =====
// Assertion macros for the RTL modules; included by spq_ctrl.
// Included by bare file name; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CHK_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define CHK_PROP(label, clk, rst_n, prop, msg)

`define CHK_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/spq_pkg.sv =====
// Types and codes of the sorted priority queue.
// No dependencies; used by spq_ctrl and sorted_priority_queue_unit.
package spq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [15:0] entry_id;
        logic [7:0]  entry_priority;
    } t_entry;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic [4:0]  occupancy;
    } t_resp;

endpackage

// ===== src/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/spq_step_unit.sv =====
// Shared step unit: circular slot address (head + position mod capacity)
// and the priority compare of one insertion step. No dependencies.
module spq_step_unit #(
    parameter int CAPACITY = 16
) (
    input  logic [$clog2(CAPACITY)-1:0] i_head,
    input  logic [$clog2(CAPACITY)-1:0] i_pos,
    input  logic [7:0]                  i_slot_priority,
    input  logic [7:0]                  i_new_priority,
    output logic [$clog2(CAPACITY)-1:0] o_addr,
    output logic                        o_later
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0] LP_CAP = (AW+1)'(CAPACITY);

    logic [AW:0] w_sum;

    always_comb begin
        w_sum = {1'b0, i_head} + {1'b0, i_pos};
        if (w_sum >= LP_CAP) begin
            w_sum = w_sum - LP_CAP;
        end
        o_addr  = w_sum[AW-1:0];
        o_later = i_slot_priority > i_new_priority;
    end

endmodule

// ===== src/spq_ctrl.sv =====
// Sequencer of the sorted priority queue: walks the circular store one
// slot per step through spq_step_unit. Depends on spq_pkg, spq_step_unit and assert_macros.svh.
`include "assert_macros.svh"

module spq_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_in_op,
    input  spq_pkg::t_entry             i_in_entry,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output spq_pkg::t_resp              o_res,
    output logic                        o_we,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output spq_pkg::t_entry             o_wdata,
    output logic [$clog2(CAPACITY)-1:0] o_raddr,
    input  spq_pkg::t_entry             i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_POP,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_head,  n_head;
    logic [AW-1:0]   r_k,     n_k;
    spq_pkg::t_entry r_new,   n_new;
    logic [1:0]      r_status, n_status;
    logic [15:0]     r_id,    n_id;
    logic [7:0]      r_pri,   n_pri;

    logic            w_accept;
    logic [AW-1:0]   w_pos;
    logic [AW-1:0]   w_addr;
    logic            w_later;

    spq_step_unit #(
        .CAPACITY (CAPACITY)
    ) u_step (
        .i_head          (r_head),
        .i_pos           (w_pos),
        .i_slot_priority (i_rdata.entry_priority),
        .i_new_priority  (r_new.entry_priority),
        .o_addr          (w_addr),
        .o_later         (w_later)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = '{status: r_status, out_id: r_id, out_priority: r_pri,
                           occupancy: 5'(r_count)};
    assign o_raddr     = w_addr;
    assign o_waddr     = w_addr;
    assign o_we        = ((r_state == S_RD) && (r_k == '0)) || (r_state == S_CMP);
    assign o_wdata     = ((r_state == S_CMP) && w_later) ? i_rdata : r_new;

    always_comb begin
        case (r_state)
            S_RD:    w_pos = (r_k == '0) ? '0 : r_k - AW'(1);
            S_CMP:   w_pos = r_k;
            S_POP:   w_pos = AW'(1);
            default: w_pos = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_k      = r_k;
        n_new    = r_new;
        n_status = r_status;
        n_id     = r_id;
        n_pri    = r_pri;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id  = '0;
                    n_pri = '0;
                    if (i_in_op == spq_pkg::OP_REMOVE) begin
                        if (r_count == '0) begin
                            n_status = spq_pkg::ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_POP;
                        end
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = spq_pkg::ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        n_new   = i_in_entry;
                        n_k     = AW'(r_count);
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_k == '0) begin
                    n_count  = r_count + CW'(1);
                    n_status = spq_pkg::ST_INSERTED;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_later) begin
                    n_k     = r_k - AW'(1);
                    n_state = S_RD;
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = spq_pkg::ST_INSERTED;
                    n_state  = S_OUT;
                end
            end
            S_POP: begin
                n_status = spq_pkg::ST_REMOVED;
                n_id     = i_rdata.entry_id;
                n_pri    = i_rdata.entry_priority;
                n_head   = w_addr;
                n_count  = r_count - CW'(1);
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_new    <= n_new;
        r_status <= n_status;
        r_id     <= n_id;
        r_pri    <= n_pri;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    `CHK_PROP(a_count_max, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `CHK_IMPL(a_cmp_pos, i_clk, i_rst_n, r_state == S_CMP, r_k != '0, "compare at slot zero")
    `CHK_IMPL(a_empty_pop, i_clk, i_rst_n, w_accept && (i_in_op == spq_pkg::OP_REMOVE) && (r_count == '0), ##1 (r_state == S_OUT) && (r_status == spq_pkg::ST_EMPTY), "remove on empty not flagged")
    `CHK_IMPL(a_count_step, i_clk, i_rst_n, r_state != S_IDLE, ##1 (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1)), "count jumped")
    `CHK_IMPL(a_we_busy, i_clk, i_rst_n, o_we, !o_in_ready, "store written while idle")

endmodule

// ===== src/sorted_priority_queue_unit.sv =====
// Sorted priority queue: an insert places an entry behind all entries of equal or
// smaller priority number, a remove pops the smallest. Entries sit in a circular
// memory of CAPACITY slots, so a remove moves nothing and an insert shifts entries
// from the tail, one slot per step of a registered memory read (S_RD) then a
// compare and write (S_CMP); an insert that reaches the head writes it from S_RD.
// A remove goes through S_POP to S_OUT and a refused item straight to S_OUT. The
// next word is accepted once the result has moved to the output register, while
// it may still wait at the output.
// Depends on spq_pkg, spq_ctrl, spq_step_unit, spq_ram.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // entry_id[15:0], entry_priority[23:16]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_id[15:0], out_priority[23:16],
                                        // occupancy[28:24], zero[31:29]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(CAPACITY);

    spq_pkg::t_entry w_in_entry;
    spq_pkg::t_entry w_wdata;
    spq_pkg::t_entry w_rdata;
    spq_pkg::t_resp  w_res;
    logic            w_res_valid;
    logic            w_res_ready;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;

    logic            r_out_valid;
    spq_pkg::t_resp  r_out;

    assign w_in_entry = '{entry_id: s_axis_tdata[15:0], entry_priority: s_axis_tdata[23:16]};
    assign w_res_ready = !r_out_valid || m_axis_tready;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_op     (s_axis_tuser),
        .i_in_entry  (w_in_entry),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    spq_ram #(
        .WIDTH ($bits(spq_pkg::t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {3'b000, r_out.occupancy, r_out.out_priority, r_out.out_id};

endmodule
